@@ hw/rtl/nrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_pkg: shared types and constants for nearest_rational_strength
// Controller states, command and status words between controller and datapath,
// register map and reset values.
// ----------------------------------------------------------------------------
package nrs_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int DEN_W             = 8;
  localparam int ADDR_W            = 3;
  localparam int DATA_W            = 32;

  localparam logic [DEN_W-1:0] MAX_DEN_RESET = 8'd6;

  // Register word index taken from paddr[2]
  localparam logic REG_MAX_DEN = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIST,
    ST_MUL_C,
    ST_CMP_C,
    ST_MUL_B,
    ST_CMP_B,
    ST_DIV,
    ST_DONE
  } nrs_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic measure;
    logic mul_c;
    logic cmp_c;
    logic mul_b;
    logic cmp_b;
    logic div_step;
    logic out_load;
  } nrs_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic div_last;
  } nrs_status_t;

endpackage

@@ hw/rtl/nearest_rational_strength.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_rational_strength: nearest bounded-denominator rational of a beat
// Finds the rational p/q, q <= max_denominator, closest to a beat position
// and returns q with its strength 2^F / q.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel beat_valid/beat_ready carries one word: beat_pos, unsigned
//   Q1.F with 2^F meaning 1.0; larger values clamp to 1.0.
//   Output channel result_valid/result_ready carries denominator and strength.
//   One result word leaves for every input word, in order.
//   The sequencer runs the Stern-Brocot mediant walk (at most
//   max_denominator - 1 steps, one per cycle), the distance compare and the
//   bit-serial reciprocal divider, which forms F + 1 quotient bits. One word
//   is in flight at a time: a new word is accepted only once the last result
//   has been loaded into the output register.
//   The output register lets the next word be accepted while a result
//   waits; if the receiver stalls, the finished result holds in the done
//   state until the output register frees.
//   Reset clears the sequencer and the output valid, and sets
//   max_denominator to 6. Write max_denominator (APB, address 0) only while
//   the block is idle; a value of 0 behaves like 1.
// ----------------------------------------------------------------------------
module nearest_rational_strength #(
  parameter int FRACTION_BITS = nrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nrs_pkg::ADDR_W-1:0]    paddr,
  input  logic [nrs_pkg::DATA_W-1:0]    pwdata,
  output logic [nrs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input words
  input  logic                          beat_valid,
  output logic                          beat_ready,
  input  logic [FRACTION_BITS:0]        beat_pos,
  // result words
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [nrs_pkg::DEN_W-1:0]     denominator,
  output logic [FRACTION_BITS:0]        strength
);

  logic [nrs_pkg::DEN_W-1:0] max_den;
  logic                      cfg_wr;
  nrs_pkg::nrs_cmd_t         cmd;
  nrs_pkg::nrs_status_t      status;

  // APB: zero wait states, register selected by word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_den <= nrs_pkg::MAX_DEN_RESET;
    end else if (cfg_wr && (paddr[2] == nrs_pkg::REG_MAX_DEN)) begin
      max_den <= pwdata[nrs_pkg::DEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == nrs_pkg::REG_MAX_DEN) begin
      prdata = {{(nrs_pkg::DATA_W - nrs_pkg::DEN_W){1'b0}}, max_den};
    end
  end

  // Sequencer: walk, compare, divide, present
  nrs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .beat_valid   (beat_valid),
    .beat_ready   (beat_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Bounds, shared cross-product multiplier, divider and output register
  nrs_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .beat_pos    (beat_pos),
    .max_den     (max_den),
    .cmd         (cmd),
    .status      (status),
    .denominator (denominator),
    .strength    (strength)
  );

endmodule

@@ hw/rtl/nrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_ctrl: sequencer for the mediant walk, compare and reciprocal
// Steps the datapath through one word at a time and owns the handshakes.
// ----------------------------------------------------------------------------
module nrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  output logic                beat_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  nrs_pkg::nrs_status_t status,
  output nrs_pkg::nrs_cmd_t   cmd
);

  nrs_pkg::nrs_state_t state;
  nrs_pkg::nrs_state_t state_next;
  logic                out_space;

  assign out_space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nrs_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      nrs_pkg::ST_IDLE:  if (beat_valid) state_next = nrs_pkg::ST_WALK;
      nrs_pkg::ST_WALK:  if (status.walk_end) state_next = nrs_pkg::ST_DIST;
      nrs_pkg::ST_DIST:  state_next = nrs_pkg::ST_MUL_C;
      nrs_pkg::ST_MUL_C: state_next = nrs_pkg::ST_CMP_C;
      nrs_pkg::ST_CMP_C: state_next = nrs_pkg::ST_MUL_B;
      nrs_pkg::ST_MUL_B: state_next = nrs_pkg::ST_CMP_B;
      nrs_pkg::ST_CMP_B: state_next = nrs_pkg::ST_DIV;
      nrs_pkg::ST_DIV:   if (status.div_last) state_next = nrs_pkg::ST_DONE;
      nrs_pkg::ST_DONE:  if (out_space) state_next = nrs_pkg::ST_IDLE;
      default:           state_next = nrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    beat_ready = 1'b0;
    case (state)
      nrs_pkg::ST_IDLE: begin
        beat_ready = 1'b1;
        cmd.load   = beat_valid;
      end
      nrs_pkg::ST_WALK:  cmd.step     = !status.walk_end;
      nrs_pkg::ST_DIST:  cmd.measure  = 1'b1;
      nrs_pkg::ST_MUL_C: cmd.mul_c    = 1'b1;
      nrs_pkg::ST_CMP_C: cmd.cmp_c    = 1'b1;
      nrs_pkg::ST_MUL_B: cmd.mul_b    = 1'b1;
      nrs_pkg::ST_CMP_B: cmd.cmp_b    = 1'b1;
      nrs_pkg::ST_DIV:   cmd.div_step = 1'b1;
      nrs_pkg::ST_DONE:  cmd.out_load = out_space;
      default:           cmd          = '0;
    endcase
  end

endmodule

@@ hw/rtl/nrs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrs_dp: mediant walk, distance compare and reciprocal datapath
// Holds the bounds, one shared multiplier, a restoring divider and the
// output word register.
// ----------------------------------------------------------------------------
module nrs_dp #(
  parameter int FRACTION_BITS = nrs_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic [FRACTION_BITS:0]         beat_pos,
  input  logic [nrs_pkg::DEN_W-1:0]      max_den,
  input  nrs_pkg::nrs_cmd_t              cmd,
  output nrs_pkg::nrs_status_t           status,
  output logic [nrs_pkg::DEN_W-1:0]      denominator,
  output logic [FRACTION_BITS:0]         strength
);

  localparam int DW  = nrs_pkg::DEN_W;
  localparam int XW  = FRACTION_BITS + 1;
  localparam int PW  = FRACTION_BITS + DW;   // x * den and num << F
  localparam int PRW = PW + DW;              // distance * den
  localparam int CW  = $clog2(FRACTION_BITS + 1);

  localparam logic [XW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [XW-1:0] x_sat;
  logic [DW-1:0] na, da, nb, db, nc, dc;
  logic [PW-1:0] xa, xb, xc;
  logic          c_valid;

  logic [PW-1:0] na_sh, nb_sh, nc_sh;
  logic [DW:0]   den_sum;
  logic [DW-1:0] num_sum;
  logic [PW-1:0] xc_w, nsum_sh;
  logic          go_low;
  logic          walk_end;
  logic          div_last;

  logic [PW-1:0]  dist_a, dist_b, dist_c;
  logic [PW-1:0]  mul_lhs;
  logic [DW-1:0]  mul_rhs;
  logic [PRW-1:0] mul_out, prod;
  logic           mul_lt;
  logic           closer_c;

  logic [DW-1:0] choice;
  logic [DW-1:0] rem;
  logic [XW-1:0] quot;
  logic [CW-1:0] cnt;
  logic [DW:0]   rsh, rdiff;
  logic          r_ge;

  assign x_sat = (beat_pos > ONE) ? ONE : beat_pos;

  // ---- walk ----
  assign na_sh   = {na, {FRACTION_BITS{1'b0}}};
  assign nb_sh   = {nb, {FRACTION_BITS{1'b0}}};
  assign nc_sh   = {nc, {FRACTION_BITS{1'b0}}};
  assign den_sum = {1'b0, da} + {1'b0, db};
  assign num_sum = na + nb;
  assign xc_w    = xa + xb;
  assign nsum_sh = {num_sum, {FRACTION_BITS{1'b0}}};
  assign go_low  = xc_w < nsum_sh;

  assign walk_end = (na_sh == xa) || (den_sum > {1'b0, max_den});
  assign status   = {walk_end, div_last};

  // xa, xb and xc track x times the matching denominator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na      <= '0;
      da      <= DW'(1);
      nb      <= DW'(1);
      db      <= DW'(1);
      nc      <= '0;
      dc      <= DW'(1);
      xa      <= {{(PW-XW){1'b0}}, x_sat};
      xb      <= {{(PW-XW){1'b0}}, x_sat};
      xc      <= '0;
      c_valid <= 1'b0;
    end else if (cmd.step) begin
      nc      <= num_sum;
      dc      <= den_sum[DW-1:0];
      xc      <= xc_w;
      c_valid <= 1'b1;
      if (go_low) begin
        nb <= num_sum;
        db <= den_sum[DW-1:0];
        xb <= xc_w;
      end else begin
        na <= num_sum;
        da <= den_sum[DW-1:0];
        xa <= xc_w;
      end
    end
  end

  // ---- scaled distances ----
  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      dist_a <= (na_sh >= xa) ? (na_sh - xa) : (xa - na_sh);
      dist_b <= (nb_sh >= xb) ? (nb_sh - xb) : (xb - nb_sh);
      dist_c <= (nc_sh >= xc) ? (nc_sh - xc) : (xc - nc_sh);
    end
  end

  // ---- shared multiplier: one cross product per cycle ----
  always_comb begin
    mul_lhs = dist_a;
    mul_rhs = db;
    if (cmd.mul_c) begin
      mul_lhs = dist_c;
      mul_rhs = da;
    end else if (cmd.cmp_c) begin
      mul_rhs = dc;
    end else if (cmd.mul_b) begin
      mul_lhs = dist_b;
      mul_rhs = da;
    end
  end

  assign mul_out = {{DW{1'b0}}, mul_lhs} * {{PW{1'b0}}, mul_rhs};
  assign mul_lt  = prod < mul_out;

  always_ff @(posedge clk) begin
    if (cmd.mul_c || cmd.mul_b) begin
      prod <= mul_out;
    end
    if (cmd.cmp_c) begin
      closer_c <= c_valid && mul_lt;
    end
    if (cmd.cmp_b) begin
      // upper bound wins over the mediant; ties keep the lower bound
      choice <= mul_lt ? db : (closer_c ? dc : da);
    end
  end

  // ---- restoring divider: 2^F / choice, one quotient bit per cycle ----
  assign rsh   = {rem, (cnt == CW'(FRACTION_BITS))};
  assign rdiff = rsh - {1'b0, choice};
  assign r_ge  = rsh >= {1'b0, choice};

  assign div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.cmp_b) begin
      rem  <= '0;
      quot <= '0;
      cnt  <= CW'(FRACTION_BITS);
    end else if (cmd.div_step) begin
      rem  <= r_ge ? rdiff[DW-1:0] : rsh[DW-1:0];
      quot <= {quot[XW-2:0], r_ge};
      cnt  <= cnt - CW'(1);
    end
  end

  // ---- output word register ----
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      denominator <= choice;
      strength    <= quot;
    end
  end

endmodule
